// ===== rtl/spq_pkg.sv =====
// Package: shared types and constants for the stable priority queue.
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 16;
    localparam int SEV_W    = 10;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ATTEND = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [SEV_W-1:0] sev;
    } entry_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   entry;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [TAG_W-1:0] entry_tag;
        logic [SEV_W-1:0] severity;
    } spq_in_t;

    typedef struct packed {
        logic [TAG_W-1:0] served_tag;
        logic [1:0]       status;
    } spq_out_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One queue slot: holds an entry and shifts with its neighbors on insert or remove.
module spq_cell
    import spq_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0] count,
    input  cell_cmd_t        cmd,
    input  entry_t           left_entry,
    input  logic             left_ge,
    input  entry_t           right_entry,
    output entry_t           entry,
    output logic             ge
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = CNT_W'(idx) < count;
    // slot stays in front of the new entry: stable among equal severities
    assign ge       = occupied && (entry_reg.sev >= cmd.entry.sev);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (!ge)
                begin
                    entry_next = left_ge ? cmd.entry : left_entry;
                end
            end
            CMD_REMOVE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/stable_priority_queue_unit.sv =====
// Top level: stable max priority queue built from a chain of sorted slot cells.
//
// Usage:
//   Request channel (req, req_valid, req_stall): one beat per command.
//     mode 0 inserts {entry_tag, severity}, mode 1 attends (removes the
//     highest severity, oldest first among equals), mode 2 clears, mode 3
//     does nothing.
//   Response channel (rsp, rsp_valid, rsp_stall): exactly one beat per
//     request beat, in order: status 0 accepted, 1 served (served_tag valid),
//     2 insert refused because full, 3 attend on empty. served_tag is 0
//     unless status is 1.
//   Latency: the response beat is valid the cycle after the request beat.
//   Throughput: one request per cycle while req_stall is low. Every slot
//     compares against the new severity in parallel and moves one place in the
//     same cycle, so the fill count update is the only serial step.
//   Stall: a single response register holds the pending beat; while it is
//     full and rsp_stall is high, req_stall is raised and the queue holds.
//   Reset: the fill count and the response valid clear; slot contents are
//     left as is and only slots below the fill count are ever read.
module stable_priority_queue_unit
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  spq_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output spq_out_t rsp
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    spq_out_t         rsp_reg;
    spq_out_t         rsp_next;

    logic             accept;
    logic             full;
    logic             empty;
    cell_cmd_t        cmd;

    entry_t           cell_entry [CAPACITY];
    logic             cell_ge    [CAPACITY];

    // response register frees up when it is empty or being taken
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign empty     = count_reg == '0;

    // command broadcast to every cell
    always_comb
    begin
        cmd.op        = CMD_HOLD;
        cmd.entry.tag = req.entry_tag;
        cmd.entry.sev = req.severity;
        if (accept)
        begin
            if (req.mode == MODE_INSERT && !full)
            begin
                cmd.op = CMD_INSERT;
            end
            else if (req.mode == MODE_ATTEND && !empty)
            begin
                cmd.op = CMD_REMOVE;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            entry_t left_entry;
            logic   left_ge;
            entry_t right_entry;

            if (gi == 0)
            begin : g_head
                assign left_entry = '0;
                assign left_ge    = 1'b1;    // head slot takes the new entry directly
            end
            else
            begin : g_body
                assign left_entry = cell_entry[gi-1];
                assign left_ge    = cell_ge[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_entry = '0;     // becomes unoccupied on remove
            end
            else
            begin : g_mid
                assign right_entry = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .idx         (IDX_W'(gi)),
                .count       (count_reg),
                .cmd         (cmd),
                .left_entry  (left_entry),
                .left_ge     (left_ge),
                .right_entry (right_entry),
                .entry       (cell_entry[gi]),
                .ge          (cell_ge[gi])
            );
        end
    endgenerate

    // fill count and response
    always_comb
    begin
        count_next          = count_reg;
        rsp_next            = rsp_reg;
        rsp_valid_next      = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.served_tag = '0;
            rsp_next.status     = ST_ACCEPTED;
            case (req.mode)
                MODE_INSERT:
                begin
                    if (full)
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_ATTEND:
                begin
                    if (empty)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.status     = ST_SERVED;
                        rsp_next.served_tag = cell_entry[0].tag;
                        count_next          = count_reg - CNT_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.mode == MODE_INSERT && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1) && rsp.status == ST_ACCEPTED)
        else $error("insert did not grow the queue");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.mode == MODE_ATTEND && empty
        |=> rsp_valid && rsp.status == ST_EMPTY && rsp.served_tag == '0)
        else $error("attend on empty not flagged");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> cell_entry[0].sev >= cell_entry[1].sev)
        else $error("head slots out of order");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the stable max priority queue unit.
module testbench
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no beat on either channel before the run is called dead.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Length of the deliberate receiver hold-off that backs the queue up.
    localparam int HOLD_CYCLES    = 300;
    // Settle time after the last reply; each reply is registered from its accepted request.
    localparam int DRAIN_CYCLES   = 8;
    // Cap on printed error lines; every error is still counted.
    localparam int PRINT_CAP      = 40;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    spq_in_t  req;
    logic     rsp_valid;
    logic     rsp_stall;
    spq_out_t rsp;

    stable_priority_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow of the waiting list: highest severity first, arrival order among equals.
    entry_t   waitlist[$];
    // Replies owed by the block, oldest first.
    spq_out_t awaited_replies[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // Idle knobs, changed by the test tasks. Percent chance per beat / per cycle.
    int  send_idle_pct  = 20;
    int  recv_stall_pct = 20;
    // Set by the test sequence to request one long receiver hold-off.
    bit  hold_off_req   = 1'b0;

    function automatic int pick_len();
        // Mostly short gaps, now and then a long one.
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Apply one accepted request to the shadow list and return the reply it earns.
    function automatic spq_out_t triage(spq_in_t b);
        spq_out_t r;
        entry_t   e;
        int       pos;
        r.served_tag = '0;
        r.status     = ST_ACCEPTED;
        case (mode_t'(b.mode))
            MODE_INSERT:
            begin
                if (waitlist.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // New entry goes behind every entry of equal or higher severity.
                    pos = 0;
                    while (pos < waitlist.size() && waitlist[pos].sev >= b.severity)
                        pos++;
                    e.tag = b.entry_tag;
                    e.sev = b.severity;
                    waitlist.insert(pos, e);
                end
            end
            MODE_ATTEND:
            begin
                if (waitlist.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    e = waitlist.pop_front();
                    r.served_tag = e.tag;
                    r.status     = ST_SERVED;
                end
            end
            MODE_CLEAR:
                waitlist.delete();
            default:
                ;   // unused mode: no effect
        endcase
        return r;
    endfunction

    function automatic spq_in_t beat(mode_t m, int tag, int sev);
        spq_in_t b;
        b.mode      = m;
        b.entry_tag = TAG_W'(tag);
        b.severity  = SEV_W'(sev);
        return b;
    endfunction

    // Random request. tie_heavy narrows severities to a few values at both ends
    // so that equal-severity ordering gets exercised hard.
    function automatic spq_in_t random_beat(int insert_pct, bit tie_heavy);
        spq_in_t b;
        int      r;
        b.entry_tag = TAG_W'($urandom());
        if (!tie_heavy)
            b.severity = SEV_W'($urandom());
        else if ($urandom_range(0, 1) == 0)
            b.severity = SEV_W'($urandom_range(0, 3));
        else
            b.severity = SEV_W'($urandom_range(1020, 1023));
        r = $urandom_range(0, 99);
        if (r < 2)
            b.mode = MODE_CLEAR;
        else if (r < 4)
            b.mode = MODE_UNUSED;
        else if ($urandom_range(0, 99) < insert_pct)
            b.mode = MODE_INSERT;
        else
            b.mode = MODE_ATTEND;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR t=%0t %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Drive one request beat at the falling edge, after an optional idle gap,
    // and hold it until a rising edge sees it taken. Valid is left high so that
    // back-to-back beats need no drop; a gap lowers it first.
    task automatic offer_request(input spq_in_t item);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            req       <= spq_in_t'($urandom());
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (req_stall);
        awaited_replies.push_back(triage(item));
    endtask

    // Reply side back-pressure: random stalls of mixed length, plus one long
    // hold-off on request, counted here so the sender keeps offering meanwhile.
    initial
    begin : reply_drain
        int left;
        left      = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rsp_stall <= 1'b0;
                left = 0;
            end
            else if (left > 0)
            begin
                left--;
                rsp_stall <= 1'b1;
            end
            else if (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct)
            begin
                left = pick_len() - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Every reply beat is checked field by field against the oldest owed reply.
    always @(posedge clk)
    begin : reply_check
        spq_out_t want;
        if (rsp_valid && !rsp_stall)
        begin
            if (awaited_replies.size() == 0)
                report_mismatch("reply beat with nothing outstanding", int'(rsp), 0);
            else
            begin
                want = awaited_replies.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", int'(rsp.status), int'(want.status));
                if (rsp.served_tag !== want.served_tag)
                    report_mismatch("served_tag", int'(rsp.served_tag),
                                    int'(want.served_tag));
            end
        end
    end

    // Dead-run guard: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hand-picked sequence: empty attend, field extremes, tie order, unused
    // mode, clear of a busy and of an empty list.
    task automatic test_directed_cases();
        offer_request(beat(MODE_ATTEND, 16'h1234, 10));      // attend on empty
        offer_request(beat(MODE_INSERT, 0, 0));
        offer_request(beat(MODE_INSERT, 16'hFFFF, 1023));
        offer_request(beat(MODE_INSERT, 16'h1111, 512));
        offer_request(beat(MODE_INSERT, 16'h2222, 512));
        offer_request(beat(MODE_INSERT, 16'h3333, 1023));    // ties the top entry
        offer_request(beat(MODE_INSERT, 16'h4444, 512));
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_UNUSED, 16'hFFFF, 1023));    // must leave list alone
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_ATTEND, 16'hFFFF, 1023));
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_ATTEND, 0, 0));              // empty again
        offer_request(beat(MODE_INSERT, 5, 1));
        offer_request(beat(MODE_INSERT, 6, 0));
        offer_request(beat(MODE_CLEAR, 16'hFFFF, 1023));
        offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_CLEAR, 0, 0));               // clear on empty
        offer_request(beat(MODE_INSERT, 16'h00AA, 1023));
        offer_request(beat(MODE_ATTEND, 0, 0));
    endtask

    // Fill to capacity, bounce off the full list, free two slots, refill.
    task automatic test_full_list();
        for (int i = 0; i < CAPACITY; i++)
        begin
            spq_in_t b;
            b      = random_beat(100, 1'b1);
            b.mode = MODE_INSERT;
            offer_request(b);
        end
        repeat (3) offer_request(beat(MODE_INSERT, $urandom(), $urandom()));
        repeat (2) offer_request(beat(MODE_ATTEND, 0, 0));
        repeat (3) offer_request(beat(MODE_INSERT, $urandom(), 1023));
        repeat (4) offer_request(beat(MODE_ATTEND, 0, 0));
        offer_request(beat(MODE_CLEAR, 0, 0));
        offer_request(beat(MODE_ATTEND, 0, 0));
    endtask

    // Random traffic in rounds; each round has its own fill bias, severity
    // spread and idle rates, so the list depth swings between empty and full.
    task automatic test_random_traffic(input int rounds);
        int bias[4] = '{25, 50, 70, 90};
        int idle[3] = '{0, 10, 40};
        for (int r = 0; r < rounds; r++)
        begin
            int ins_pct;
            bit ties;
            ins_pct        = bias[$urandom_range(0, 3)];
            ties           = 1'($urandom_range(0, 1));
            send_idle_pct  = idle[$urandom_range(0, 2)];
            recv_stall_pct = idle[$urandom_range(0, 2)];
            repeat (50) offer_request(random_beat(ins_pct, ties));
        end
        send_idle_pct  = 20;
        recv_stall_pct = 20;
    endtask

    // Long receiver hold-off while the sender streams without gaps, so the
    // reply register fills and the request side has to stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_off_req  = 1'b1;
        repeat (60) offer_request(random_beat(60, 1'b0));
        send_idle_pct = 20;
    endtask

    // Full-rate stretch with no idling on either side.
    task automatic test_full_rate();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (200) offer_request(random_beat(55, 1'($urandom_range(0, 1))));
        send_idle_pct  = 20;
        recv_stall_pct = 20;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_full_list();
        test_random_traffic(13);
        test_backpressure();
        test_random_traffic(13);
        test_full_rate();

        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue_unit.sv
test/testbench.sv
